FILE: rtl/first_fit_heap_allocator_top_assert.svh
// Assertion macros for the allocator checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define FFA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Check that cons holds in the cycle after ante.
`define FFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

FILE: rtl/ffa_pkg.sv
// Shared codes and widths of the first-fit heap allocator.
package ffa_pkg;

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_ALLOC = 2'd0;
    localparam cmd_t CMD_FREE  = 2'd1;
    localparam cmd_t CMD_INIT  = 2'd2;
    localparam cmd_t CMD_RSVD  = 2'd3;

    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_NOMEM   = 3'd1;
    localparam status_t ST_ILLEGAL = 3'd2;
    localparam status_t ST_BADHDR  = 3'd3;
    localparam status_t ST_FREED   = 3'd4;
    localparam status_t ST_FULL    = 3'd5;

    localparam logic [DATA_W-1:0] HEAP_RESET = 32'd1048576;

endpackage

FILE: rtl/first_fit_heap_allocator_top.sv
// First-fit heap allocator with coalescing: top level, sequencer and descriptor table.
//
// The block keeps an address-ordered list of heap block descriptors (offset, size, used,
// next) in a RAM of MAX_BLOCKS entries; entry zero is always the list head. One request is
// taken at a time and s_axis_tready stays low until its single result has been placed in
// the output register. An allocate walks the list, a RAM read and then a check for each
// descriptor visited, then looks for a spare descriptor one entry at a time (round robin,
// at most MAX_BLOCKS entries tried) and writes the split: the free remainder first, then
// the granted descriptor. A free walks the list the same way for the lookup, clears the
// used mark, then makes a merge pass over the whole list: each descriptor is read and
// checked; a free one that is not the last absorbs each free neighbour that follows it, up
// to the first used one, and is written back. The RAM has a single read and write port.
// A reinitialise or an unknown command goes straight to placing its result. Reset and
// reinitialise clear all per-entry valid bits together, so no clearing pass is needed; an
// entry never written reads as its reset contents. heap_bytes is sampled at reset and at a
// reinitialise and may only be written while the block is idle.
module first_fit_heap_allocator_top
    import ffa_pkg::*;
#(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16,
    parameter int ADDR_BITS    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: heap_bytes
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] req_size, [63:32] data_offset
    input  logic [7:0]  s_axis_tuser,   // [1:0] cmd, [7:2] zero
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] alloc_offset, [63:32] avail_bytes
    output logic [7:0]  m_axis_tuser    // [2:0] status, [7:3] zero
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int NXT_W = IDX_W + 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [NXT_W-1:0] NIL = NXT_W'(MAX_BLOCKS);
    localparam logic [DATA_W-1:0] SPAN_MASK =
        (ADDR_BITS >= 32) ? '1 : DATA_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [DATA_W-1:0] HDR = DATA_W'(HEADER_BYTES);
    localparam logic [MAX_BLOCKS-1:0] SPARE_INIT = {{(MAX_BLOCKS-1){1'b1}}, 1'b0};

    typedef struct packed {
        logic [NXT_W-1:0]  nxt;
        logic              used;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] offs;
    } desc_t;

    localparam int DESC_W = $bits(desc_t);

    typedef enum logic [3:0] {
        S_IDLE, S_ARD, S_ACHK, S_SCAN, S_SPLIT, S_GRANT,
        S_FRD, S_FCHK, S_FCLR, S_CRD, S_CCHK, S_NRD, S_NCHK, S_CWB, S_DONE
    } state_t;

    function automatic logic [DATA_W-1:0] first_size(input logic [DATA_W-1:0] hb);
        logic [DATA_W-1:0] span;
        span = hb & SPAN_MASK;
        return (span >= HDR) ? span - HDR : '0;
    endfunction

    state_t              state_reg, state_next;
    logic [DATA_W-1:0]   heap_reg, heap_next;
    logic [DATA_W-1:0]   init_size_reg, init_size_next;
    logic [DATA_W-1:0]   avail_reg, avail_next;
    logic [MAX_BLOCKS-1:0] valid_reg, valid_next;
    logic [MAX_BLOCKS-1:0] spare_reg, spare_next;
    logic [CNT_W-1:0]    spare_cnt_reg, spare_cnt_next;
    logic [IDX_W-1:0]    scan_reg, scan_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [NXT_W-1:0]    cur_reg, cur_next;
    logic [IDX_W-1:0]    m_idx_reg, m_idx_next;
    logic [IDX_W-1:0]    n_idx_reg, n_idx_next;
    desc_t               m_desc_reg, m_desc_next;
    logic [DATA_W-1:0]   req_reg, req_next;
    logic [DATA_W:0]     req_total_reg, req_total_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    status_t             res_status_reg, res_status_next;
    logic [DATA_W-1:0]   res_offset_reg, res_offset_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [DATA_W-1:0]   out_offset_reg, out_offset_next;
    logic [DATA_W-1:0]   out_avail_reg, out_avail_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    desc_t               ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [DESC_W-1:0]   ram_rdata;
    desc_t               q;
    cmd_t                in_cmd;

    ffa_ram #(
        .WIDTH (DESC_W),
        .DEPTH (MAX_BLOCKS)
    ) u_desc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_cmd = s_axis_tuser[CMD_W-1:0];

    // An entry never written since reset or reinitialise reads as its reset contents.
    always_comb
    begin
        if (valid_reg[rd_idx_reg])
        begin
            q = desc_t'(ram_rdata);
        end
        else
        begin
            q.nxt  = NIL;
            q.used = 1'b0;
            q.size = (rd_idx_reg == '0) ? init_size_reg : '0;
            q.offs = '0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        heap_next       = heap_reg;
        init_size_next  = init_size_reg;
        avail_next      = avail_reg;
        valid_next      = valid_reg;
        spare_next      = spare_reg;
        spare_cnt_next  = spare_cnt_reg;
        scan_next       = scan_reg;
        rd_idx_next     = rd_idx_reg;
        cur_next        = cur_reg;
        m_idx_next      = m_idx_reg;
        n_idx_next      = n_idx_reg;
        m_desc_next     = m_desc_reg;
        req_next        = req_reg;
        req_total_next  = req_total_reg;
        data_next       = data_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_offset_next = out_offset_reg;
        out_avail_next  = out_avail_reg;
        ram_we          = 1'b0;
        ram_waddr       = m_idx_reg;
        ram_wdata       = m_desc_reg;
        ram_raddr       = '0;

        // drop the result once the consumer has taken it
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            heap_next = cfg_wdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next        = s_axis_tdata[DATA_W-1:0];
                    data_next       = s_axis_tdata[2*DATA_W-1:DATA_W];
                    req_total_next  = {1'b0, s_axis_tdata[DATA_W-1:0]} + {1'b0, HDR};
                    res_status_next = ST_OK;
                    res_offset_next = '0;
                    cur_next        = '0;
                    unique case (in_cmd)
                        CMD_ALLOC:
                        begin
                            state_next = S_ARD;
                        end
                        CMD_FREE:
                        begin
                            if (s_axis_tdata[2*DATA_W-1:DATA_W] > (heap_reg & SPAN_MASK))
                            begin
                                res_status_next = ST_ILLEGAL;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FRD;
                            end
                        end
                        CMD_INIT:
                        begin
                            valid_next     = '0;
                            spare_next     = SPARE_INIT;
                            spare_cnt_next = CNT_W'(MAX_BLOCKS - 1);
                            init_size_next = first_size(heap_reg);
                            avail_next     = first_size(heap_reg);
                            state_next     = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // first-fit walk
            S_ARD:
            begin
                ram_raddr   = cur_reg[IDX_W-1:0];
                rd_idx_next = cur_reg[IDX_W-1:0];
                state_next  = S_ACHK;
            end
            S_ACHK:
            begin
                if (!q.used && ({1'b0, q.size} >= req_total_reg))
                begin
                    m_idx_next  = rd_idx_reg;
                    m_desc_next = q;
                    if (spare_cnt_reg == '0)
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                else if (q.nxt == NIL)
                begin
                    res_status_next = ST_NOMEM;
                    state_next      = S_DONE;
                end
                else
                begin
                    cur_next   = q.nxt;
                    state_next = S_ARD;
                end
            end
            S_SCAN:
            begin
                if (spare_reg[scan_reg])
                begin
                    n_idx_next = scan_reg;
                    state_next = S_SPLIT;
                end
                else
                begin
                    scan_next = (scan_reg == IDX_W'(MAX_BLOCKS - 1)) ? '0 : scan_reg + 1'b1;
                end
            end
            S_SPLIT:
            begin
                // write the free remainder
                ram_we         = 1'b1;
                ram_waddr      = n_idx_reg;
                ram_wdata.nxt  = m_desc_reg.nxt;
                ram_wdata.used = 1'b0;
                ram_wdata.size = DATA_W'({1'b0, m_desc_reg.size} - req_total_reg);
                ram_wdata.offs = DATA_W'({1'b0, m_desc_reg.offs} + req_total_reg);
                valid_next[n_idx_reg] = 1'b1;
                spare_next[n_idx_reg] = 1'b0;
                spare_cnt_next = spare_cnt_reg - 1'b1;
                state_next     = S_GRANT;
            end
            S_GRANT:
            begin
                ram_we         = 1'b1;
                ram_waddr      = m_idx_reg;
                ram_wdata.nxt  = {1'b0, n_idx_reg};
                ram_wdata.used = 1'b1;
                ram_wdata.size = req_reg;
                ram_wdata.offs = m_desc_reg.offs;
                valid_next[m_idx_reg] = 1'b1;
                avail_next = ({1'b0, avail_reg} >= req_total_reg)
                           ? DATA_W'({1'b0, avail_reg} - req_total_reg) : '0;
                res_offset_next = (m_desc_reg.offs + HDR) & SPAN_MASK;
                state_next      = S_DONE;
            end

            // free lookup
            S_FRD:
            begin
                ram_raddr   = cur_reg[IDX_W-1:0];
                rd_idx_next = cur_reg[IDX_W-1:0];
                state_next  = S_FCHK;
            end
            S_FCHK:
            begin
                if (({1'b0, q.offs} + {1'b0, HDR}) == {1'b0, data_reg})
                begin
                    if (!q.used)
                    begin
                        res_status_next = ST_FREED;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        m_idx_next  = rd_idx_reg;
                        m_desc_next = q;
                        state_next  = S_FCLR;
                    end
                end
                else if (q.nxt == NIL)
                begin
                    res_status_next = ST_BADHDR;
                    state_next      = S_DONE;
                end
                else
                begin
                    cur_next   = q.nxt;
                    state_next = S_FRD;
                end
            end
            S_FCLR:
            begin
                ram_we         = 1'b1;
                ram_waddr      = m_idx_reg;
                ram_wdata      = m_desc_reg;
                ram_wdata.used = 1'b0;
                valid_next[m_idx_reg] = 1'b1;
                cur_next       = '0;
                state_next     = S_CRD;
            end

            // merge pass from the head
            S_CRD:
            begin
                ram_raddr   = cur_reg[IDX_W-1:0];
                rd_idx_next = cur_reg[IDX_W-1:0];
                state_next  = S_CCHK;
            end
            S_CCHK:
            begin
                m_idx_next  = rd_idx_reg;
                m_desc_next = q;
                if (!q.used && (q.nxt != NIL))
                begin
                    state_next = S_NRD;
                end
                else if (q.nxt == NIL)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = q.nxt;
                    state_next = S_CRD;
                end
            end
            S_NRD:
            begin
                ram_raddr   = m_desc_reg.nxt[IDX_W-1:0];
                rd_idx_next = m_desc_reg.nxt[IDX_W-1:0];
                state_next  = S_NCHK;
            end
            S_NCHK:
            begin
                if (!q.used)
                begin
                    // absorb the neighbour and hand its descriptor back
                    m_desc_next.size = m_desc_reg.size + HDR + q.size;
                    m_desc_next.nxt  = q.nxt;
                    spare_next[rd_idx_reg] = 1'b1;
                    spare_cnt_next = spare_cnt_reg + 1'b1;
                    state_next     = (q.nxt != NIL) ? S_NRD : S_CWB;
                end
                else
                begin
                    state_next = S_CWB;
                end
            end
            S_CWB:
            begin
                ram_we    = 1'b1;
                ram_waddr = m_idx_reg;
                ram_wdata = m_desc_reg;
                valid_next[m_idx_reg] = 1'b1;
                if (m_desc_reg.nxt == NIL)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = m_desc_reg.nxt;
                    state_next = S_CRD;
                end
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_offset_next = (res_status_reg == ST_OK) ? res_offset_reg : '0;
                    out_avail_next  = avail_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            heap_reg       <= HEAP_RESET;
            init_size_reg  <= first_size(HEAP_RESET);
            avail_reg      <= first_size(HEAP_RESET);
            valid_reg      <= '0;
            spare_reg      <= SPARE_INIT;
            spare_cnt_reg  <= CNT_W'(MAX_BLOCKS - 1);
            scan_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            heap_reg       <= heap_next;
            init_size_reg  <= init_size_next;
            avail_reg      <= avail_next;
            valid_reg      <= valid_next;
            spare_reg      <= spare_next;
            spare_cnt_reg  <= spare_cnt_next;
            scan_reg       <= scan_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        cur_reg        <= cur_next;
        m_idx_reg      <= m_idx_next;
        n_idx_reg      <= n_idx_next;
        m_desc_reg     <= m_desc_next;
        req_reg        <= req_next;
        req_total_reg  <= req_total_next;
        data_reg       <= data_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        out_status_reg <= out_status_next;
        out_offset_reg <= out_offset_next;
        out_avail_reg  <= out_avail_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_avail_reg, out_offset_reg};
    assign m_axis_tuser  = {5'd0, out_status_reg};

endmodule

FILE: rtl/ffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ffa_checker.sv
// Port-level checker of the allocator, bound to the top level.
`include "first_fit_heap_allocator_top_assert.svh"

module ffa_checker
    import ffa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [7:0]  m_axis_tuser
);

    `FFA_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `FFA_ASSERT_NEXT(a_result_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `FFA_ASSERT_NOW(a_status_known, m_axis_tvalid, m_axis_tuser[2:0] <= ST_FULL)
    `FFA_ASSERT_NOW(a_fail_no_offset, m_axis_tvalid && (m_axis_tuser[2:0] != ST_OK), m_axis_tdata[31:0] == 32'd0)

endmodule

bind first_fit_heap_allocator_top ffa_checker u_ffa_checker (.*);

FILE: bench/tb_first_fit_heap_allocator_top.sv
// Self-checking testbench for the first-fit heap allocator: directed and random requests.
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator_top;
    import ffa_pkg::*;

    localparam int NBLK = 64;
    localparam int HDR  = 16;
    localparam int NIL  = NBLK;
    localparam longint CYCLE_LIMIT = 4000000;

    // Result of one request as the block should return it.
    typedef struct packed {
        status_t     status;
        logic [31:0] alloc_offset;
        logic [31:0] avail_bytes;
    } alloc_result_t;

    // Shadow allocator plus queue of results still owed by the block.
    class heap_scoreboard;
        logic [31:0]   heap_span;
        logic [31:0]   base_q   [NBLK];
        logic [31:0]   len_q    [NBLK];
        bit            busy_q   [NBLK];
        int            link_q   [NBLK];
        bit            spare_q  [NBLK];
        logic [31:0]   avail;
        alloc_result_t owed[$];
        int            errors;
        logic [31:0]   live_offsets[$];

        function new();
            heap_span = HEAP_RESET;
            errors    = 0;
            rebuild();
        endfunction

        function void rebuild();
            for (int i = 0; i < NBLK; i++)
            begin
                base_q[i]  = 0;
                len_q[i]   = 0;
                busy_q[i]  = 0;
                link_q[i]  = NIL;
                spare_q[i] = (i != 0);
            end
            len_q[0] = (heap_span >= HDR) ? heap_span - HDR : 0;
            avail    = len_q[0];
            live_offsets.delete();
        endfunction

        function status_t grant(logic [31:0] size, output logic [31:0] offs);
            logic [33:0] need;
            int m;
            int steps;
            int n;
            need  = {2'b0, size} + HDR;
            m     = 0;
            steps = 0;
            n     = -1;
            offs  = 0;
            while (m < NBLK && steps < NBLK)
            begin
                if (!busy_q[m] && {2'b0, len_q[m]} >= need)
                    break;
                m = link_q[m];
                steps++;
            end
            if (m >= NBLK || steps >= NBLK)
                return ST_NOMEM;
            for (int i = 0; i < NBLK; i++)
                if (spare_q[i] && n < 0)
                    n = i;
            if (n < 0)
                return ST_FULL;
            spare_q[n] = 0;
            base_q[n]  = base_q[m] + need[31:0];
            len_q[n]   = len_q[m] - need[31:0];
            busy_q[n]  = 0;
            link_q[n]  = link_q[m];
            busy_q[m]  = 1;
            len_q[m]   = size;
            link_q[m]  = n;
            avail      = ({2'b0, avail} >= need) ? avail - need[31:0] : 0;
            offs       = base_q[m] + HDR;
            live_offsets.push_back(offs);
            return ST_OK;
        endfunction

        function void merge_free();
            int m;
            int steps;
            int n;
            m     = 0;
            steps = 0;
            while (m < NBLK && steps < NBLK)
            begin
                while (!busy_q[m] && link_q[m] < NBLK && !busy_q[link_q[m]])
                begin
                    n          = link_q[m];
                    len_q[m]   = len_q[m] + HDR + len_q[n];
                    link_q[m]  = link_q[n];
                    link_q[n]  = NIL;
                    spare_q[n] = 1;
                end
                m = link_q[m];
                steps++;
            end
        endfunction

        function status_t release_block(logic [31:0] data);
            int m;
            int steps;
            m     = 0;
            steps = 0;
            if (data > heap_span)
                return ST_ILLEGAL;
            while (m < NBLK && steps < NBLK)
            begin
                if ({1'b0, base_q[m]} + HDR == {1'b0, data})
                    break;
                m = link_q[m];
                steps++;
            end
            if (m >= NBLK || steps >= NBLK)
                return ST_BADHDR;
            if (!busy_q[m])
                return ST_FREED;
            busy_q[m] = 0;
            merge_free();
            return ST_OK;
        endfunction

        // Note an accepted request and queue the result it must produce.
        function void note_request(cmd_t cmd, logic [31:0] size, logic [31:0] data);
            alloc_result_t r;
            logic [31:0] offs;
            r.status = ST_OK;
            offs     = 0;
            if (cmd == CMD_ALLOC)
                r.status = grant(size, offs);
            else if (cmd == CMD_FREE)
                r.status = release_block(data);
            else if (cmd == CMD_INIT)
                rebuild();
            r.alloc_offset = (r.status == ST_OK) ? offs : 0;
            r.avail_bytes  = avail;
            owed.push_back(r);
        endfunction

        // Compare one accepted result with the oldest owed one.
        function void check_result(status_t st, logic [31:0] offs, logic [31:0] av);
            alloc_result_t e;
            if (owed.size() == 0)
            begin
                $error("result with nothing owed: status %0d", st);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (offs !== e.alloc_offset)
            begin
                $error("alloc_offset: expected %0h, got %0h", e.alloc_offset, offs);
                errors++;
            end
            if (av !== e.avail_bytes)
            begin
                $error("avail_bytes: expected %0h, got %0h", e.avail_bytes, av);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [7:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [7:0]  m_axis_tuser;

    heap_scoreboard board;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_results;
    longint      cycles;

    first_fit_heap_allocator_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: give up well beyond the slowest legal run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: sample at the rising edge, change tready at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(status_t'(m_axis_tuser[2:0]), m_axis_tdata[31:0],
                               m_axis_tdata[63:32]);
    end

    always @(negedge clk)
    begin
        if (!rst_n || hold_results)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one request and hold it until the block takes it. Leave tvalid up on return:
    // the block is busy then, and the next request or a drain takes it down.
    task automatic send_request(cmd_t cmd, logic [31:0] size, logic [31:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {6'b0, cmd};
        s_axis_tdata  <= {data, size};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_request(cmd, size, data);
        @(negedge clk);
    endtask

    // Drain every owed result, then let a failed or idle walk finish.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.owed.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    // Write heap_bytes while idle and start over from it.
    task automatic set_heap(logic [31:0] span);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= span;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.heap_span = span;
        send_request(CMD_INIT, $urandom, $urandom);
    endtask

    // Pick a size mostly small, sometimes huge, so the table both fills and runs dry.
    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(256);
        if (r < 90)
            return $urandom_range(65536);
        return $urandom;
    endfunction

    // Pick a free address: live blocks mostly, otherwise stale or random offsets.
    function automatic logic [31:0] pick_free();
        int r;
        r = $urandom_range(99);
        if (r < 65 && board.live_offsets.size() != 0)
            return board.live_offsets[$urandom_range(board.live_offsets.size() - 1)];
        if (r < 80)
            return $urandom_range(HDR * 4);
        if (r < 90)
            return board.heap_span + $urandom_range(1, 8);
        return $urandom;
    endfunction

    task automatic random_phase(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 50)
                send_request(CMD_ALLOC, pick_size(), $urandom);
            else if (r < 96)
                send_request(CMD_FREE, $urandom, pick_free());
            else if (r < 98)
                send_request(CMD_INIT, $urandom, $urandom);
            else
                send_request(CMD_RSVD, $urandom, $urandom);
        end
    endtask

    initial
    begin
        board         = new();
        cycles        = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        hold_results  = 1'b0;
        send_idle_pct = 8;
        recv_idle_pct = 88;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes of each field, every command, every error status.
        send_request(CMD_ALLOC, 32'd0, 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, 32'd100, 32'd0);
        send_request(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);   // no memory
        send_request(CMD_FREE, 32'd0, 32'd16);           // first block
        send_request(CMD_FREE, 32'd0, 32'd16);           // double free
        send_request(CMD_FREE, 32'hFFFF_FFFF, 32'd5);    // below header: bad header
        send_request(CMD_FREE, 32'd0, 32'hFFFF_FFFF);    // outside heap
        send_request(CMD_FREE, 32'd0, HEAP_RESET);       // top edge, no block there
        send_request(CMD_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Exhaust the descriptor table with zero-byte grants.
        for (int i = 0; i < 66; i++)
            send_request(CMD_ALLOC, 32'd0, 32'd0);
        send_request(CMD_INIT, 32'd0, 32'd0);

        // Tiny heap, then the all-ones heap.
        set_heap(32'd3);
        send_request(CMD_ALLOC, 32'd0, 32'd0);
        send_request(CMD_FREE, 32'd0, 32'd4);
        set_heap(32'd0);
        send_request(CMD_ALLOC, 32'd0, 32'd0);
        set_heap(32'hFFFF_FFFF);
        send_request(CMD_ALLOC, 32'hFFFF_FFEF, 32'd0);
        send_request(CMD_ALLOC, 32'hFFFF_FFF0, 32'd0);
        send_request(CMD_FREE, 32'd0, 32'd16);

        set_heap(32'd4096);
        random_phase(550);

        // Pressure: hold the result side a long while so the input stalls.
        hold_results = 1'b1;
        fork
        begin
            repeat (2000) @(negedge clk);
            hold_results = 1'b0;
        end
        random_phase(20);
        join
        wait_drained();

        send_idle_pct = 88;
        recv_idle_pct = 8;
        set_heap($urandom_range(16, 65536));
        random_phase(550);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_heap(HEAP_RESET);
        random_phase(600);

        wait_drained();
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
